/* hdl/hsv_pkg.sv */
// Shared types and constants for the RGB to HSV converter.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package hsv_pkg;

    // Which channel holds the maximum (red wins ties, then green)
    typedef enum logic [1:0] {
        SECT_RED   = 2'd0,
        SECT_GREEN = 2'd1,
        SECT_BLUE  = 2'd2
    } sector_t;

    // One division request: dividend < 2^24, divisor in 1..255
    typedef struct packed {
        logic [23:0] dividend;
        logic [7:0]  divisor;
    } div_op_t;

    // Lane slots inside the divider
    localparam logic [0:0] LANE_HUE = 1'b0;
    localparam logic [0:0] LANE_SAT = 1'b1;

    // floor((2^32 - 1) / d) for one 8-bit d, by restoring long division
    function automatic logic [31:0] recip_entry(input int d);
        logic [8:0]  rem;
        logic [8:0]  den;
        logic [31:0] quo;
        den = 9'(d);
        rem = '0;
        quo = '0;
        if (d != 0)
        begin
            for (int i = 31; i >= 0; i--)
            begin
                rem = {rem[7:0], 1'b1};
                quo = {quo[30:0], 1'b0};
                if (rem >= den)
                begin
                    rem    = rem - den;
                    quo[0] = 1'b1;
                end
            end
        end
        return quo;
    endfunction

endpackage

`default_nettype wire

/* hdl/hsv_prep.sv */
// Front half of the converter: channel split, max/min, sector numerator.
// Four register stages; emits two division requests per pixel. Uses hsv_pkg.
`default_nettype none

module hsv_prep
    import hsv_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [23:0]         pixel,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output div_op_t [1:0]            out_op,
    output logic [7:0]               out_brightness
);

    localparam logic [24:0] HUE_MUL     = 25'd10922;   // floor(65536 / 6)
    localparam logic [28:0] THIRD_MUL   = 29'd43691;   // ceil(2^17 / 3)
    localparam int          THIRD_SHIFT = 17;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic en1, en2, en3, en4;

    // stage 1: raw channels
    logic [7:0] r1_reg, g1_reg, b1_reg;
    // stage 2: max, delta, sector
    logic [7:0] r2_reg, g2_reg, b2_reg, mx2_reg, delta2_reg;
    sector_t    sect2_reg;
    // stage 3: numerator and saturation request
    logic [10:0] num3_reg;
    logic [7:0]  delta3_reg, mx3_reg, sat_d3_reg;
    logic [23:0] sat_a3_reg;
    // stage 4: division requests
    div_op_t [1:0] op4_reg;
    logic [7:0]    mx4_reg;

    logic [7:0]  mx2_next, mn2_next, delta2_next;
    sector_t     sect2_next;
    logic [10:0] num3_next;
    logic [10:0] delta_x2, delta_x4, delta_x6;
    logic [24:0] hue_prod;
    logic [28:0] third_prod;
    logic [11:0] num_x2;
    logic [23:0] hue_a4_next;

    // advance a stage when it is empty or its successor takes its item
    assign en4      = !s4_valid_reg || out_ready;
    assign en3      = !s3_valid_reg || en4;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) s1_valid_reg <= in_valid;
            if (en2) s2_valid_reg <= s1_valid_reg;
            if (en3) s3_valid_reg <= s2_valid_reg;
            if (en4) s4_valid_reg <= s3_valid_reg;
        end
    end

    // max and min, red first then green on ties
    always_comb
    begin
        if (r1_reg >= g1_reg && r1_reg >= b1_reg)
        begin
            mx2_next   = r1_reg;
            sect2_next = SECT_RED;
        end
        else if (g1_reg >= b1_reg)
        begin
            mx2_next   = g1_reg;
            sect2_next = SECT_GREEN;
        end
        else
        begin
            mx2_next   = b1_reg;
            sect2_next = SECT_BLUE;
        end
        mn2_next = r1_reg;
        if (g1_reg < mn2_next) mn2_next = g1_reg;
        if (b1_reg < mn2_next) mn2_next = b1_reg;
        delta2_next = mx2_next - mn2_next;
    end

    // sector numerator, below 6 * delta (zero when delta is zero); wraps cancel out in 11 bits
    always_comb
    begin
        delta_x2 = {2'b0, delta2_reg, 1'b0};
        delta_x4 = {1'b0, delta2_reg, 2'b0};
        delta_x6 = delta_x2 + delta_x4;
        unique case (sect2_reg)
            SECT_RED:
                if (g2_reg >= b2_reg)
                    num3_next = 11'(g2_reg) - 11'(b2_reg);
                else
                    num3_next = delta_x6 - (11'(b2_reg) - 11'(g2_reg));
            SECT_GREEN: num3_next = delta_x2 + 11'(b2_reg) - 11'(r2_reg);
            SECT_BLUE:  num3_next = delta_x4 + 11'(r2_reg) - 11'(g2_reg);
            default:    num3_next = '0;
        endcase
    end

    // floor(num * 65536 / 6) = num * 10922 + floor(2 * num / 3)
    always_comb
    begin
        num_x2      = {num3_reg, 1'b0};
        hue_prod    = 25'(num3_reg) * HUE_MUL;
        third_prod  = 29'(num_x2) * THIRD_MUL;
        hue_a4_next = 24'(hue_prod + 25'(third_prod[28:THIRD_SHIFT]));
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            r1_reg <= pixel[7:0];
            g1_reg <= pixel[15:8];
            b1_reg <= pixel[23:16];
        end
        if (en2 && s1_valid_reg)
        begin
            r2_reg     <= r1_reg;
            g2_reg     <= g1_reg;
            b2_reg     <= b1_reg;
            mx2_reg    <= mx2_next;
            delta2_reg <= delta2_next;
            sect2_reg  <= sect2_next;
        end
        if (en3 && s2_valid_reg)
        begin
            num3_reg   <= num3_next;
            delta3_reg <= delta2_reg;
            mx3_reg    <= mx2_reg;
            // delta * 65535; zero whenever max is zero
            sat_a3_reg <= {delta2_reg, 16'b0} - 24'(delta2_reg);
            sat_d3_reg <= (mx2_reg == 8'd0) ? 8'd1 : mx2_reg;
        end
        if (en4 && s3_valid_reg)
        begin
            op4_reg[LANE_HUE].dividend <= (delta3_reg == 8'd0) ? 24'd0 : hue_a4_next;
            op4_reg[LANE_HUE].divisor  <= (delta3_reg == 8'd0) ? 8'd1 : delta3_reg;
            op4_reg[LANE_SAT].dividend <= sat_a3_reg;
            op4_reg[LANE_SAT].divisor  <= sat_d3_reg;
            mx4_reg                    <= mx3_reg;
        end
    end

    assign out_valid      = s4_valid_reg;
    assign out_op         = op4_reg;
    assign out_brightness = mx4_reg;

`ifndef SYNTHESIS
    a_delta_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (delta2_reg <= mx2_reg))
        else $error("hsv_prep: delta exceeds max");

    a_num_in_turn: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> ((delta3_reg == 8'd0 && num3_reg == 11'd0) ||
                          (num3_reg < 11'(delta3_reg) * 11'd6)))
        else $error("hsv_prep: hue numerator outside one turn");
`endif

endmodule

`default_nettype wire

/* hdl/hsv_div.sv */
// Two-lane pipelined divider: 24-bit dividend by 8-bit divisor, 16-bit quotient.
// Reciprocal lookup, multiply, remainder, one-step correction. Uses hsv_pkg.
`default_nettype none

module hsv_div
    import hsv_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire div_op_t [1:0]       in_op,
    input  wire logic [7:0]          in_tag,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [1:0][15:0]         out_quot,
    output logic [7:0]               out_tag
);

    logic d1_valid_reg, d2_valid_reg, d3_valid_reg, d4_valid_reg;
    logic en1, en2, en3, en4;

    logic [31:0] recip_tab [256];

    logic [23:0] a1_reg [2];
    logic [7:0]  d1_reg [2];
    logic [31:0] rcp1_reg [2];
    logic [23:0] a2_reg [2];
    logic [7:0]  d2_reg [2];
    logic [15:0] q2_reg [2];
    logic [7:0]  d3_reg [2];
    logic [15:0] q3_reg [2];
    logic [8:0]  rem3_reg [2];
    logic [15:0] q4_reg [2];
    logic [7:0]  tag1_reg, tag2_reg, tag3_reg, tag4_reg;

    logic [55:0] prod_next [2];
    logic [23:0] rem_next [2];

    // constant reciprocal table, one entry per divisor value
    for (genvar gd = 0; gd < 256; gd++)
    begin : g_recip
        assign recip_tab[gd] = recip_entry(gd);
    end

    assign en4      = !d4_valid_reg || out_ready;
    assign en3      = !d3_valid_reg || en4;
    assign en2      = !d2_valid_reg || en3;
    assign en1      = !d1_valid_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_valid_reg <= 1'b0;
            d2_valid_reg <= 1'b0;
            d3_valid_reg <= 1'b0;
            d4_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) d1_valid_reg <= in_valid;
            if (en2) d2_valid_reg <= d1_valid_reg;
            if (en3) d3_valid_reg <= d2_valid_reg;
            if (en4) d4_valid_reg <= d3_valid_reg;
        end
    end

    // estimate is exact or one low since the reciprocal error stays under 2^-8
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            prod_next[l] = 56'(a1_reg[l]) * 56'(rcp1_reg[l]);
            rem_next[l]  = a2_reg[l] - 24'(q2_reg[l]) * 24'(d2_reg[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            for (int l = 0; l < 2; l++)
            begin
                a1_reg[l]   <= in_op[l].dividend;
                d1_reg[l]   <= in_op[l].divisor;
                rcp1_reg[l] <= recip_tab[in_op[l].divisor];
            end
            tag1_reg <= in_tag;
        end
        if (en2 && d1_valid_reg)
        begin
            for (int l = 0; l < 2; l++)
            begin
                a2_reg[l] <= a1_reg[l];
                d2_reg[l] <= d1_reg[l];
                q2_reg[l] <= prod_next[l][47:32];
            end
            tag2_reg <= tag1_reg;
        end
        if (en3 && d2_valid_reg)
        begin
            for (int l = 0; l < 2; l++)
            begin
                d3_reg[l]   <= d2_reg[l];
                q3_reg[l]   <= q2_reg[l];
                rem3_reg[l] <= rem_next[l][8:0];
            end
            tag3_reg <= tag2_reg;
        end
        if (en4 && d3_valid_reg)
        begin
            for (int l = 0; l < 2; l++)
                q4_reg[l] <= q3_reg[l] + 16'(rem3_reg[l] >= {1'b0, d3_reg[l]});
            tag4_reg <= tag3_reg;
        end
    end

    always_comb
    begin
        for (int l = 0; l < 2; l++)
            out_quot[l] = q4_reg[l];
    end

    assign out_valid = d4_valid_reg;
    assign out_tag   = tag4_reg;

`ifndef SYNTHESIS
    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        d3_valid_reg |-> (rem3_reg[0] < {d3_reg[0], 1'b0} &&
                          rem3_reg[1] < {d3_reg[1], 1'b0}))
        else $error("hsv_div: remainder beyond one correction step");
`endif

endmodule

`default_nettype wire

/* hdl/rgb_to_hsv_converter_top.sv */
// Top level of the RGB to HSV converter: hsv_prep feeding hsv_div.
// Depends on hsv_pkg, hsv_prep and hsv_div.
`default_nettype none

// Takes one packed pixel (red bits 7:0, green 15:8, blue 23:16) per clock and
// returns brightness = max channel, saturation = floor(65535*delta/max) and
// hue = floor(65536*h) as a fraction of a turn; black and gray give hue and
// saturation of zero. Throughput is one pixel per clock while the output is
// not stalled. Four stages form the max/min and sector numerator, four more
// run the two divisions through a 256-entry reciprocal table, a 24x32
// multiply and a single correction step.
// Both sides use valid/ready; each stage holds its item under backpressure and
// empty stages fill, so a new pixel is taken while a result waits at the output.
module rgb_to_hsv_converter_top
    import hsv_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [23:0] pixel,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      hue,
    output logic [15:0]      saturation,
    output logic [7:0]       brightness
);

    logic            prep_valid;
    logic            prep_ready;
    div_op_t [1:0]   prep_op;
    logic [7:0]      prep_brightness;
    logic [1:0][15:0] quot;

    hsv_prep u_prep (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .pixel          (pixel),
        .out_valid      (prep_valid),
        .out_ready      (prep_ready),
        .out_op         (prep_op),
        .out_brightness (prep_brightness)
    );

    hsv_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_op     (prep_op),
        .in_tag    (prep_brightness),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_quot  (quot),
        .out_tag   (brightness)
    );

    assign hue        = quot[LANE_HUE];
    assign saturation = quot[LANE_SAT];

`ifndef SYNTHESIS
    a_black_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && brightness == 8'd0) |-> (hue == 16'd0 && saturation == 16'd0))
        else $error("rgb_to_hsv_converter_top: black pixel with nonzero hue or saturation");

    a_gray_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturation == 16'd0) |-> (hue == 16'd0))
        else $error("rgb_to_hsv_converter_top: gray pixel with nonzero hue");
`endif

endmodule

`default_nettype wire
